/* rtl/core/nal_unit_splitter_defines.svh */
// ----------------------------------------------------------------------------
// nal_unit_splitter_defines
// Assertion macros shared by the NAL unit splitter.
// ----------------------------------------------------------------------------
`ifndef NAL_UNIT_SPLITTER_DEFINES_SVH
`define NAL_UNIT_SPLITTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NUS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define NUS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/nus_pkg.sv */
// ----------------------------------------------------------------------------
// nus_pkg
// Types and constants of the NAL unit splitter.
// ----------------------------------------------------------------------------
package nus_pkg;

  localparam int BUFFER_BYTES_MAX = 1048576;
  localparam int POS_W            = $clog2(BUFFER_BYTES_MAX);
  localparam int LEN_W            = 20;
  localparam int OFS_W            = 48;
  localparam int TYPE_W           = 5;
  localparam int IDX_W            = 32;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_AW          = $clog2(FIFO_DEPTH);

  localparam logic [7:0] START_CODE_END = 8'h01;

  localparam logic [TYPE_W-1:0] TYPE_IDR = 5'd5;
  localparam logic [TYPE_W-1:0] TYPE_SEI = 5'd6;
  localparam logic [TYPE_W-1:0] TYPE_SPS = 5'd7;
  localparam logic [TYPE_W-1:0] TYPE_PPS = 5'd8;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [OFS_W-1:0]   ofs_t;
  typedef logic [FIFO_AW-1:0] fifo_ptr_t;
  typedef logic [FIFO_AW:0]   fifo_cnt_t;

  // unit descriptor handed from front to back
  typedef struct packed {
    ofs_t              base;
    pos_t              start;
    len_t              len;
    logic [TYPE_W-1:0] utype;
    logic              param_set;
    logic              keyframe;
  } nus_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nus_fifo_stat_t;

endpackage

/* rtl/core/nus_if.sv */
// ----------------------------------------------------------------------------
// nus_if
// Valid/ready channels for the byte input and the unit result.
// ----------------------------------------------------------------------------
interface nus_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [47:0] buffer_base;

  modport source (output valid, data_byte, last_byte, buffer_base, input ready);
  modport sink   (input valid, data_byte, last_byte, buffer_base, output ready);
endinterface

interface nus_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] unit_offset;
  logic [19:0] unit_length;
  logic [4:0]  unit_type;
  logic        is_parameter_set;
  logic        is_keyframe;
  logic [31:0] sample_index;

  modport source (output valid, unit_offset, unit_length, unit_type, is_parameter_set,
                  is_keyframe, sample_index, input ready);
  modport sink   (input valid, unit_offset, unit_length, unit_type, is_parameter_set,
                  is_keyframe, sample_index, output ready);
endinterface

/* rtl/core/nus_front.sv */
// ----------------------------------------------------------------------------
// nus_front
// Start-code scanner: tracks zero runs and unit bounds per byte and pushes
// a descriptor for every closed non-SEI unit.
// ----------------------------------------------------------------------------
module nus_front (
  input  logic                   clk,
  input  logic                   rst_n,
  nus_in_if.sink                 in_ch,
  input  nus_pkg::nus_fifo_stat_t fifo_stat,
  output logic                   push,
  output nus_pkg::nus_desc_t     push_desc
);

  logic              in_unit_r, in_unit_nxt;
  logic [1:0]        zero_run_r, zero_run_nxt;
  nus_pkg::pos_t     byte_pos_r, byte_pos_nxt;
  nus_pkg::pos_t     unit_start_r, unit_start_nxt;
  logic [7:0]        header_r, header_nxt;
  logic              header_seen_r, header_seen_nxt;
  nus_pkg::ofs_t     base_r, base_nxt;

  logic              fire;
  logic              last;
  logic              is_zero;
  logic              le_one;
  logic              emit_end;
  logic              emit_last;
  logic [1:0]        zero_bump;
  logic [nus_pkg::TYPE_W-1:0] utype;
  nus_pkg::pos_t     len_end;
  nus_pkg::pos_t     len_last;

  assign in_ch.ready = !fifo_stat.full;
  assign fire        = in_ch.valid && in_ch.ready;

  assign last    = in_ch.last_byte ||
                   (byte_pos_r == nus_pkg::pos_t'(nus_pkg::BUFFER_BYTES_MAX - 1));
  assign is_zero = (in_ch.data_byte == 8'h00);
  assign le_one  = (in_ch.data_byte <= nus_pkg::START_CODE_END);
  assign zero_bump = is_zero ? ((zero_run_r == 2'd3) ? 2'd3 : zero_run_r + 2'd1) : 2'd0;

  assign emit_end  = in_unit_r && (zero_run_r >= 2'd2) && le_one;
  assign emit_last = last && in_unit_r && !emit_end;
  assign len_end   = byte_pos_r - nus_pkg::pos_t'(2) - unit_start_r;
  assign len_last  = byte_pos_r + nus_pkg::pos_t'(1) - unit_start_r;

  always_comb begin
    in_unit_nxt     = in_unit_r;
    zero_run_nxt    = zero_run_r;
    byte_pos_nxt    = byte_pos_r;
    unit_start_nxt  = unit_start_r;
    header_nxt      = header_r;
    header_seen_nxt = header_seen_r;
    base_nxt        = base_r;
    if (fire) begin
      if (byte_pos_r == '0) begin
        base_nxt = in_ch.buffer_base;
      end
      if (!in_unit_r) begin
        if ((in_ch.data_byte == nus_pkg::START_CODE_END) && (zero_run_r >= 2'd2)) begin
          in_unit_nxt     = 1'b1;
          unit_start_nxt  = byte_pos_r + nus_pkg::pos_t'(1);
          header_seen_nxt = 1'b0;
          zero_run_nxt    = 2'd0;
        end else begin
          zero_run_nxt = zero_bump;
        end
      end else begin
        if (!header_seen_r) begin
          header_nxt      = in_ch.data_byte;
          header_seen_nxt = 1'b1;
        end
        if (emit_end) begin
          if (!is_zero) begin
            unit_start_nxt  = byte_pos_r + nus_pkg::pos_t'(1);
            header_seen_nxt = 1'b0;
            zero_run_nxt    = 2'd0;
          end else begin
            in_unit_nxt  = 1'b0;
            zero_run_nxt = 2'd3;
          end
        end else begin
          zero_run_nxt = zero_bump;
        end
      end
      if (last) begin
        in_unit_nxt     = 1'b0;
        header_seen_nxt = 1'b0;
        zero_run_nxt    = 2'd0;
        byte_pos_nxt    = '0;
      end else begin
        byte_pos_nxt = byte_pos_r + nus_pkg::pos_t'(1);
      end
    end
  end

  // header as seen by this byte
  assign utype = (in_unit_r && !header_seen_r) ? in_ch.data_byte[nus_pkg::TYPE_W-1:0]
                                               : header_r[nus_pkg::TYPE_W-1:0];

  always_comb begin
    push_desc.base      = base_nxt;
    push_desc.start     = unit_start_r;
    push_desc.len       = emit_end ? nus_pkg::len_t'(len_end) : nus_pkg::len_t'(len_last);
    push_desc.utype     = utype;
    push_desc.param_set = (utype == nus_pkg::TYPE_SPS) || (utype == nus_pkg::TYPE_PPS);
    push_desc.keyframe  = (utype == nus_pkg::TYPE_IDR);
  end

  assign push = fire && (emit_end || emit_last) && (utype != nus_pkg::TYPE_SEI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_unit_r     <= 1'b0;
      zero_run_r    <= 2'd0;
      byte_pos_r    <= '0;
      unit_start_r  <= '0;
      header_r      <= 8'h00;
      header_seen_r <= 1'b0;
      base_r        <= '0;
    end else begin
      in_unit_r     <= in_unit_nxt;
      zero_run_r    <= zero_run_nxt;
      byte_pos_r    <= byte_pos_nxt;
      unit_start_r  <= unit_start_nxt;
      header_r      <= header_nxt;
      header_seen_r <= header_seen_nxt;
      base_r        <= base_nxt;
    end
  end

endmodule

/* rtl/core/nus_fifo.sv */
// ----------------------------------------------------------------------------
// nus_fifo
// Short descriptor queue between scanner and result stage.
// ----------------------------------------------------------------------------
module nus_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  nus_pkg::nus_desc_t      push_desc,
  input  logic                    pop,
  output nus_pkg::nus_desc_t      pop_desc,
  output nus_pkg::nus_fifo_stat_t stat
);

  nus_pkg::nus_desc_t  mem_r [nus_pkg::FIFO_DEPTH];
  nus_pkg::fifo_ptr_t  wr_ptr_r, wr_ptr_nxt;
  nus_pkg::fifo_ptr_t  rd_ptr_r, rd_ptr_nxt;
  nus_pkg::fifo_cnt_t  cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == nus_pkg::fifo_cnt_t'(nus_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_desc   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + nus_pkg::fifo_ptr_t'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + nus_pkg::fifo_ptr_t'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + nus_pkg::fifo_cnt_t'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - nus_pkg::fifo_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/nus_back.sv */
// ----------------------------------------------------------------------------
// nus_back
// Result stage: forms the file offset, numbers the unit and holds it in the
// output register until transfer.
// ----------------------------------------------------------------------------
module nus_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nus_pkg::nus_fifo_stat_t fifo_stat,
  input  nus_pkg::nus_desc_t      pop_desc,
  output logic                    pop,
  nus_out_if.source               out_ch
);

  logic                        valid_r, valid_nxt;
  logic [nus_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  nus_pkg::ofs_t               offset_r;
  nus_pkg::len_t               length_r;
  logic [nus_pkg::TYPE_W-1:0]  type_r;
  logic                        pset_r;
  logic                        key_r;
  logic [nus_pkg::IDX_W-1:0]   sample_r;
  nus_pkg::ofs_t               offset_nxt;

  assign pop        = !fifo_stat.empty && (!valid_r || out_ch.ready);
  assign offset_nxt = pop_desc.base + nus_pkg::ofs_t'(pop_desc.start);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (pop) begin
      valid_nxt = 1'b1;
      idx_nxt   = idx_r + nus_pkg::IDX_W'(1);
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      offset_r <= offset_nxt;
      length_r <= pop_desc.len;
      type_r   <= pop_desc.utype;
      pset_r   <= pop_desc.param_set;
      key_r    <= pop_desc.keyframe;
      sample_r <= idx_r;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.unit_offset      = offset_r;
  assign out_ch.unit_length      = length_r;
  assign out_ch.unit_type        = type_r;
  assign out_ch.is_parameter_set = pset_r;
  assign out_ch.is_keyframe      = key_r;
  assign out_ch.sample_index     = sample_r;

endmodule

/* rtl/core/nal_unit_splitter.sv */
// Throughput: one byte per cycle; in_ch.ready drops only while the 4-entry unit queue is full.
// Result path: a unit's descriptor is written to the queue on the transfer of the byte that closes it,
// and is loaded into the output register when the result stage pops it from the queue.
// Reset: synchronous active-low rst_n clears scan state, buffer position, sample index,
// the queue and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// nal_unit_splitter
// Annex B byte stream to NAL unit descriptors: scanner, queue, result stage.
// ----------------------------------------------------------------------------
`include "nal_unit_splitter_defines.svh"

module nal_unit_splitter (
  input  logic       clk,
  input  logic       rst_n,
  nus_in_if.sink     in_ch,
  nus_out_if.source  out_ch
);

  logic                    push;
  logic                    pop;
  nus_pkg::nus_desc_t      push_desc;
  nus_pkg::nus_desc_t      pop_desc;
  nus_pkg::nus_fifo_stat_t fifo_stat;

  nus_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  nus_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .stat      (fifo_stat)
  );

  nus_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .pop_desc  (pop_desc),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  `NUS_ASSERT_NOW(a_no_overflow, push, !fifo_stat.full, "push into full queue")
  `NUS_ASSERT_NOW(a_no_underflow, pop, !fifo_stat.empty, "pop from empty queue")
  `NUS_ASSERT_NOW(a_no_sei_out, out_ch.valid, (out_ch.unit_type != nus_pkg::TYPE_SEI) && !(out_ch.is_parameter_set && out_ch.is_keyframe), "bad unit class on output")
  `NUS_ASSERT_NEXT(a_pop_loads, pop, out_ch.valid, "popped unit not presented")

endmodule
